@@ src/lis_pkg.sv @@
// ---------------------------------------------------------------------------
// lis_pkg: shared types for the increasing subsequence unit
// Payload structs of both channels and the token flags that ride the cell row.
// ---------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     final_res;
  } out_item_t;

  // flags of the token that moves one cell per cycle
  typedef struct packed {
    logic valid;   // carries a stored sequence element
    logic placed;  // a cell has already taken the value as its tail
    logic opened;  // the value opened a new pile
    logic close;   // closes the sequence
  } tok_ctl_t;

endpackage

@@ src/longest_increasing_subsequence_unit.sv @@
// ---------------------------------------------------------------------------
// longest_increasing_subsequence_unit: strictly increasing subsequence finder
// Patience sorting on a row of pile cells, then a backward walk that
// rebuilds one longest strictly increasing subsequence, emitted oldest first.
// ---------------------------------------------------------------------------
//
//  channel  signals                          transfer
//  -------  -------------------------------  ---------------------------------
//  in       in_valid_i in_ready_o in_data_i  one sequence value, last closes
//  out      out_valid_o out_ready_i out_data_o one subsequence element
//
// Values of a sequence transfer one per cycle; each enters the cell row and
// moves one cell per cycle, so its pile is known once it leaves the row.
// After the closing value the input stalls while the row drains, while the
// highest pile is searched and the backward walk runs (one store read per
// element visited in each), while each result is loaded and held until
// taken, and while the piles are cleared. Reset empties every pile at once.
// Values beyond MAX_ITEMS in one sequence are dropped; a dropped value with
// last set still closes the sequence.
// ---------------------------------------------------------------------------
module longest_increasing_subsequence_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lis_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lis_pkg::out_item_t  out_data_o
);
  import lis_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic PH_COLLECT = 1'b0;
  localparam logic PH_BUSY    = 1'b1;

  logic             phase_q;
  logic [CNT_W-1:0] item_cnt_q;
  logic             in_xfer;
  logic             keep;
  logic             seq_done;

  // token links between cells; link 0 feeds the first cell
  tok_ctl_t                 ctl_l   [MAX_ITEMS+1];
  logic signed [DATA_W-1:0] value_l [MAX_ITEMS+1];
  logic        [IDX_W-1:0]  idx_l   [MAX_ITEMS+1];
  logic        [IDX_W-1:0]  pile_l  [MAX_ITEMS+1];

  assign in_ready_o = (phase_q == PH_COLLECT);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign keep       = item_cnt_q < CNT_W'(MAX_ITEMS);

  // inject the accepted value; a dropped value only carries the close flag
  always_comb begin
    ctl_l[0]        = '0;
    ctl_l[0].valid  = in_xfer && keep;
    ctl_l[0].close  = in_xfer && in_data_i.last;
    value_l[0]      = in_data_i.value;
    idx_l[0]        = item_cnt_q[IDX_W-1:0];
    pile_l[0]       = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_COLLECT;
      item_cnt_q <= '0;
    end else begin
      if (seq_done) begin
        phase_q    <= PH_COLLECT;
        item_cnt_q <= '0;
      end else if (in_xfer) begin
        if (keep) begin
          item_cnt_q <= item_cnt_q + CNT_W'(1);
        end
        if (in_data_i.last) begin
          phase_q <= PH_BUSY;
        end
      end
    end
  end

  // row of pile cells; cell k keeps the tail of pile k
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    lis_cell #(
      .IDX_W   (IDX_W),
      .CELL_IDX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clr_i  (seq_done),
      .ctl_i  (ctl_l[k]),
      .value_i(value_l[k]),
      .idx_i  (idx_l[k]),
      .pile_i (pile_l[k]),
      .ctl_o  (ctl_l[k+1]),
      .value_o(value_l[k+1]),
      .idx_o  (idx_l[k+1]),
      .pile_o (pile_l[k+1])
    );
  end

  lis_backtrack #(
    .MAX_ITEMS(MAX_ITEMS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_backtrack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl_l[MAX_ITEMS]),
    .value_i    (value_l[MAX_ITEMS]),
    .idx_i      (idx_l[MAX_ITEMS]),
    .pile_i     (pile_l[MAX_ITEMS]),
    .item_cnt_i (item_cnt_q),
    .done_o     (seq_done),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ src/lis_cell.sv @@
// ---------------------------------------------------------------------------
// lis_cell: one pile of the patience row
// Holds the tail of one pile and registers the passing token for the next cell.
// ---------------------------------------------------------------------------
module lis_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               clr_i,
  input  lis_pkg::tok_ctl_t                  ctl_i,
  input  logic signed [lis_pkg::DATA_W-1:0]  value_i,
  input  logic        [IDX_W-1:0]            idx_i,
  input  logic        [IDX_W-1:0]            pile_i,
  output lis_pkg::tok_ctl_t                  ctl_o,
  output logic signed [lis_pkg::DATA_W-1:0]  value_o,
  output logic        [IDX_W-1:0]            idx_o,
  output logic        [IDX_W-1:0]            pile_o
);
  import lis_pkg::*;

  logic signed [DATA_W-1:0] tail_q;
  logic                     used_q;
  logic                     take;
  tok_ctl_t                 ctl_q, ctl_d;
  logic signed [DATA_W-1:0] value_q;
  logic        [IDX_W-1:0]  idx_q;
  logic        [IDX_W-1:0]  pile_q;

  // first pile whose tail is at or above the value, or the first empty pile
  assign take = ctl_i.valid && !ctl_i.placed && (!used_q || (tail_q >= value_i));

  always_comb begin
    ctl_d = ctl_i;
    if (take) begin
      ctl_d.placed = 1'b1;
      ctl_d.opened = !used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      ctl_q  <= '0;
    end else begin
      ctl_q <= ctl_d;
      if (clr_i) begin
        used_q <= 1'b0;
      end else if (take) begin
        used_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_i;
    idx_q   <= idx_i;
    pile_q  <= take ? IDX_W'(CELL_IDX) : pile_i;
    if (take) begin
      tail_q <= value_i;
    end
  end

  assign ctl_o   = ctl_q;
  assign value_o = value_q;
  assign idx_o   = idx_q;
  assign pile_o  = pile_q;

endmodule

@@ src/lis_backtrack.sv @@
// ---------------------------------------------------------------------------
// lis_backtrack: element store, pile walk and result output
// Records tokens leaving the cell row, then rebuilds and emits the subsequence.
// ---------------------------------------------------------------------------
module lis_backtrack #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned CNT_W     = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lis_pkg::tok_ctl_t                  ctl_i,
  input  logic signed [lis_pkg::DATA_W-1:0]  value_i,
  input  logic        [IDX_W-1:0]            idx_i,
  input  logic        [IDX_W-1:0]            pile_i,
  input  logic        [CNT_W-1:0]            item_cnt_i,
  output logic                               done_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lis_pkg::out_item_t                 out_data_o
);
  import lis_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_FIND_RD   = 3'd1;
  localparam logic [2:0] S_FIND_CHK  = 3'd2;
  localparam logic [2:0] S_WALK_RD   = 3'd3;
  localparam logic [2:0] S_WALK_CHK  = 3'd4;
  localparam logic [2:0] S_EMIT_RD   = 3'd5;
  localparam logic [2:0] S_EMIT_WAIT = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic signed [DATA_W-1:0] elem_mem [MAX_ITEMS];
  logic        [IDX_W-1:0]  pile_mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] seq_mem  [MAX_ITEMS];

  logic [2:0]               state_q, state_d;
  logic [IDX_W-1:0]         addr_q, addr_d;
  logic [IDX_W-1:0]         k_q, k_d;
  logic [IDX_W-1:0]         emit_q, emit_d;
  logic [CNT_W-1:0]         pile_cnt_q, pile_cnt_d;
  logic signed [DATA_W-1:0] rd_elem_q;
  logic [IDX_W-1:0]         rd_pile_q;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_elem_q;
  logic                     out_final_q;
  logic                     seq_we;
  logic [IDX_W-1:0]         seq_wa;
  logic [IDX_W-1:0]         top_pile;
  logic                     at_end;
  logic                     emit_load;

  assign top_pile = IDX_W'(pile_cnt_q - CNT_W'(1));
  assign at_end   = (CNT_W'(addr_q) + CNT_W'(1)) >= item_cnt_i;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    k_d         = k_q;
    emit_d      = emit_q;
    pile_cnt_d  = pile_cnt_q;
    out_valid_d = out_valid_q;
    seq_we      = 1'b0;
    seq_wa      = k_q;
    emit_load   = 1'b0;
    if (ctl_i.valid && ctl_i.opened) begin
      pile_cnt_d = pile_cnt_q + CNT_W'(1);
    end
    case (state_q)
      S_IDLE: begin
        if (ctl_i.close) begin
          addr_d  = '0;
          state_d = (pile_cnt_d == '0) ? S_DONE : S_FIND_RD;
        end
      end
      S_FIND_RD: state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        // earliest element on the highest pile
        if (rd_pile_q == top_pile || at_end) begin
          seq_we = 1'b1;
          seq_wa = top_pile;
          k_d    = top_pile;
          if (addr_q == '0 || top_pile == '0) begin
            emit_d  = '0;
            state_d = S_EMIT_RD;
          end else begin
            addr_d  = addr_q - IDX_W'(1);
            state_d = S_WALK_RD;
          end
        end else begin
          addr_d  = addr_q + IDX_W'(1);
          state_d = S_FIND_RD;
        end
      end
      S_WALK_RD: state_d = S_WALK_CHK;
      S_WALK_CHK: begin
        // latest earlier element of the next lower pile
        if (rd_pile_q == k_q - IDX_W'(1)) begin
          seq_we = 1'b1;
          seq_wa = k_q - IDX_W'(1);
          k_d    = k_q - IDX_W'(1);
        end
        if (addr_q == '0 || k_d == '0) begin
          emit_d  = '0;
          state_d = S_EMIT_RD;
        end else begin
          addr_d  = addr_q - IDX_W'(1);
          state_d = S_WALK_RD;
        end
      end
      S_EMIT_RD: begin
        emit_load   = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_final_q) begin
            state_d = S_DONE;
          end else begin
            emit_d  = emit_q + IDX_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      S_DONE: begin
        pile_cnt_d = '0;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pile_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pile_cnt_q  <= pile_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    k_q    <= k_d;
    emit_q <= emit_d;
  end

  // element and pile store, one write port from the row, one read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      elem_mem[idx_i] <= value_i;
      pile_mem[idx_i] <= pile_i;
    end
    rd_elem_q <= elem_mem[addr_q];
    rd_pile_q <= pile_mem[addr_q];
  end

  // subsequence buffer, filled newest first and read oldest first
  always_ff @(posedge clk_i) begin
    if (seq_we) begin
      seq_mem[seq_wa] <= rd_elem_q;
    end
    if (emit_load) begin
      out_elem_q  <= seq_mem[emit_q];
      out_final_q <= (emit_q == top_pile);
    end
  end

  assign done_o                = (state_q == S_DONE);
  assign out_valid_o           = out_valid_q;
  assign out_data_o.element    = out_elem_q;
  assign out_data_o.final_res  = out_final_q;

endmodule

@@ verif/lis_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lis_scoreboard_pkg: predictor and result check for the subsequence unit
// Folds each value that fits into its own pile table and, on a closing
// value, queues the subsequence that the unit must emit.
// ---------------------------------------------------------------------------
package lis_scoreboard_pkg;

  import lis_pkg::*;

  class lis_scoreboard #(int unsigned DEPTH = 64);

    // own copy of the sequence state
    bit signed [DATA_W-1:0] values [DEPTH];
    bit        [5:0]        pile_idx [DEPTH];
    bit signed [DATA_W-1:0] pile_tail [DEPTH];
    bit        [6:0]        n_stored;
    bit        [6:0]        n_piles;

    out_item_t expected_subseq [$];

    int unsigned n_values;
    int unsigned n_dropped;
    int unsigned n_sequences;
    int unsigned n_checked;
    int unsigned n_errors;

    function new();
      n_stored    = '0;
      n_piles     = '0;
      n_values    = 0;
      n_dropped   = 0;
      n_sequences = 0;
      n_checked   = 0;
      n_errors    = 0;
    endfunction

    // accepted input transfer: place the value, emit the chain on close
    function void note_value(in_item_t item);
      int unsigned lo, hi, mid, top, pos, k, i;
      bit signed [DATA_W-1:0] chain [DEPTH];
      out_item_t res;
      n_values++;
      if (n_stored < DEPTH) begin
        // first tail at or above the value
        lo = 0;
        hi = n_piles;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (pile_tail[mid] >= item.value) hi = mid;
          else lo = mid + 1;
        end
        pile_tail[lo] = item.value;
        if (lo == n_piles) n_piles++;
        values[n_stored]   = item.value;
        pile_idx[n_stored] = 6'(lo);
        n_stored++;
      end else begin
        n_dropped++;
      end
      if (!item.last) return;
      n_sequences++;
      if (n_stored == 0 || n_piles == 0) begin
        n_stored = '0;
        n_piles  = '0;
        return;
      end
      // earliest element of the highest pile, then walk backward
      top = n_piles - 1;
      pos = 0;
      while (pos + 1 < n_stored && pile_idx[pos] != top) pos++;
      k        = top;
      chain[k] = values[pos];
      i        = pos;
      while (i > 0 && k > 0) begin
        i--;
        if (pile_idx[i] == k - 1) begin
          k--;
          chain[k] = values[i];
        end
      end
      for (i = 0; i < n_piles; i++) begin
        res.element   = chain[i];
        res.final_res = (i + 1 == n_piles);
        expected_subseq.push_back(res);
      end
      n_stored = '0;
      n_piles  = '0;
    endfunction

    // accepted output transfer against the oldest queued element
    function void check_element(out_item_t got);
      out_item_t want;
      if (expected_subseq.size() == 0) begin
        $error("unexpected result: element=%0d final_res=%0b", got.element, got.final_res);
        n_errors++;
        return;
      end
      want = expected_subseq.pop_front();
      n_checked++;
      if (got.element !== want.element) begin
        $error("element: expected %0d, actual %0d", want.element, got.element);
        n_errors++;
      end
      if (got.final_res !== want.final_res) begin
        $error("final_res: expected %0b, actual %0b", want.final_res, got.final_res);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_subseq.size();
    endfunction

  endclass

endpackage

@@ verif/tb_longest_increasing_subsequence_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_longest_increasing_subsequence_unit: self-checking bench for the unit
// Directed sequences at the value extremes and the tie cases, then random
// sequences of mixed shapes with random idle on both channels; every output
// transfer is checked against a scoreboard that predicts the subsequence.
// ---------------------------------------------------------------------------
module tb_longest_increasing_subsequence_unit;

  import lis_pkg::*;
  import lis_scoreboard_pkg::*;

  localparam int unsigned MAX_ITEMS  = 64;
  localparam int unsigned RAND_ITEMS = 250;
  // drain of the row, search and walk over a full store, emission: margin
  localparam int unsigned TAIL_WAIT  = MAX_ITEMS * 8;

  localparam bit signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam bit signed [DATA_W-1:0] VAL_MAX  = 32'sh7FFF_FFFE;
  localparam bit signed [DATA_W-1:0] VAL_SENT = 32'sh7FFF_FFFF;  // old sentinel value

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  // no idling on either side while set
  bit quiet;

  lis_scoreboard #(MAX_ITEMS) sb;

  longest_increasing_subsequence_unit #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // sink side: ready drops with a chance of 9 in 100, changed on the falling
  // edge so the rising edge sees a settled value
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = quiet || ($urandom_range(0, 99) >= 9);
    end
  end

  // every output transfer goes to the scoreboard
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_element(out_data_o);
    end
  end

  // one input transfer; entered and left at a falling edge. Valid is only
  // lowered for an idle gap, never between back-to-back items.
  task automatic send_value(input bit signed [DATA_W-1:0] v, input bit is_last);
    in_item_t item;
    int unsigned gap;
    item.value = v;
    item.last  = is_last;
    if (!quiet && $urandom_range(0, 99) < 9) begin
      gap        = $urandom_range(1, 3);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_value(item);
    @(negedge clk_i);
  endtask

  // whole sequence from an array, last set on the final entry
  task automatic send_seq(input bit signed [DATA_W-1:0] seq [$]);
    foreach (seq[i]) send_value(seq[i], i == seq.size() - 1);
  endtask

  // random value of a given shape; position feeds the rising trend
  function automatic bit signed [DATA_W-1:0] pick_value(int unsigned shape, int unsigned pos);
    bit signed [DATA_W-1:0] v;
    case (shape)
      0: v = $urandom;                                      // full range, all bits
      1: v = $signed($urandom_range(0, 15)) - 8;            // many ties
      2: v = $signed(pos * 6) + $signed($urandom_range(0, 20)) - 500;  // rising, noisy
      default: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = VAL_SENT;
          3: v = -1;
          4: v = 0;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    int unsigned sent, len, shape, n_seq;
    bit signed [DATA_W-1:0] seq [$];

    sb          = new();
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed part ---
    // single-item sequences at the low end and next to the high end of the range
    seq = '{VAL_MAX};                         send_seq(seq);
    seq = '{VAL_MIN};                         send_seq(seq);
    // equal values share one pile
    seq = '{5, 5, 5};                         send_seq(seq);
    // strictly falling
    seq = '{4, 2};                            send_seq(seq);
    // rising through the extremes, ending on the former sentinel value
    seq = '{VAL_MIN, -1, 0, 1, VAL_MAX, VAL_SENT};  send_seq(seq);
    // mixed, with ties in the reconstruction
    seq = '{3, 1, 4, 1, 5, 9, 2, 6};          send_seq(seq);
    // value equal to an existing tail
    seq = '{2, 7, 7, 3, 7};                   send_seq(seq);

    // --- random part ---
    sent  = 0;
    n_seq = 0;
    while (sent < RAND_ITEMS) begin
      quiet = (sent >= 100 && sent < 170);
      // an overflowing sequence early and one late; closing item is dropped
      if (n_seq == 2 || n_seq == 20) len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 5);
      else if ($urandom_range(0, 99) < 88) len = $urandom_range(1, 12);
      else len = $urandom_range(13, 40);
      shape = $urandom_range(0, 3);
      for (int unsigned i = 0; i < len; i++) send_value(pick_value(shape, i), i == len - 1);
      sent += len;
      n_seq++;
    end
    in_valid_i = 1'b0;
    quiet      = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Covered %0d values in %0d sequences, %0d dropped past capacity,",
             sb.n_values, sb.n_sequences, sb.n_dropped);
    $display("and checked %0d subsequence elements.", sb.n_checked);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ longest_increasing_subsequence_unit.f @@
src/lis_pkg.sv
src/lis_cell.sv
src/lis_backtrack.sv
src/longest_increasing_subsequence_unit.sv
verif/lis_scoreboard_pkg.sv
verif/tb_longest_increasing_subsequence_unit.sv
